@@ hdl/rpwe_pkg.sv @@
// rpwe_pkg: shared types and codes for the read priority write elevator
// no dependencies
package rpwe_pkg;

    localparam int QueueDepth   = 32;
    localparam int EntryWidth   = 64;
    localparam int RdBurstReset = 48;
    localparam int WrBurstReset = 16;

    typedef logic [EntryWidth-1:0] t_entry;   // {tag, cylinder, block}

    typedef enum logic [1:0] {
        CMD_PUT  = 2'd0,
        CMD_PEEK = 2'd1,
        CMD_GET  = 2'd2,
        CMD_NOP  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        CHOICE_NONE  = 2'd0,
        CHOICE_READ  = 2'd1,
        CHOICE_WRITE = 2'd2,
        CHOICE_SPARE = 2'd3
    } t_choice;

    typedef enum logic [1:0] {
        CFG_SORT_BY_CYL = 2'd0,
        CFG_RD_BURST    = 2'd1,
        CFG_WR_BURST    = 2'd2,
        CFG_UNUSED      = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        CHAIN_HOLD   = 2'd0,
        CHAIN_INSERT = 2'd1,
        CHAIN_REMOVE = 2'd2,
        CHAIN_SPARE  = 2'd3
    } t_chain_op;

    typedef enum logic [1:0] {
        CELL_HOLD = 2'd0,
        CELL_NEW  = 2'd1,
        CELL_PREV = 2'd2,
        CELL_NEXT = 2'd3
    } t_cell_op;

    typedef struct packed {
        logic [1:0]  command;
        logic [15:0] req_tag;
        logic        is_read;
        logic [15:0] cylinder;
        logic [31:0] block_number;
    } t_in;

    typedef struct packed {
        logic        accepted;
        logic        found;
        logic [15:0] out_tag;
        logic        out_is_read;
        logic [15:0] out_cylinder;
        logic [31:0] out_block;
    } t_out;

    typedef struct packed {
        t_chain_op op;
        logic      use_new;
    } t_chain_ctl;

endpackage

@@ hdl/read_priority_write_elevator.sv @@
// read_priority_write_elevator: disk request scheduler top level
// depends on rpwe_pkg, rpwe_chain and rpwe_cell
//
// Disk request scheduler. A put stores a request: reads join a first-in
// first-out chain of cells, writes are inserted into a second chain kept in
// ascending key order and served as a one-way circular scan from a cursor.
// A peek or get picks the current request (reads in bursts of up to
// read_burst_limit plus one, then up to write_burst_limit writes when
// both queues hold requests) and keeps that pick until a get removes it.
// Each transaction is taken in while idle; then in the compare state every
// write cell compares its key with the new request in parallel; then in the
// execute state the insert position ripples down the cell row, all cells
// shift at once and the result is registered. Execute waits while the
// result register is held by a stalled output. A new transaction is taken
// only when the previous one has left the execute state. There is no
// clearing pass after reset.
module read_priority_write_elevator #(
    parameter int QUEUE_DEPTH = rpwe_pkg::QueueDepth
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    // request side
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  rpwe_pkg::t_in i_in_data,
    // result side
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output rpwe_pkg::t_out o_out_data,
    // configuration writes
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_idx,
    input  logic [7:0]    i_cfg_data
);
    import rpwe_pkg::*;

    localparam int IDXW = $clog2(QUEUE_DEPTH);
    localparam int CNTW = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CMP  = 3'b010,
        S_EXEC = 3'b100
    } t_state;

    t_state r_state, n_state;

    // configuration registers
    logic       r_sort_cyl;
    logic [7:0] r_rd_limit;
    logic [7:0] r_wr_limit;

    // scheduler state
    logic [CNTW-1:0] r_rd_count, n_rd_count;
    logic [CNTW-1:0] r_wr_count, n_wr_count;
    logic [IDXW-1:0] r_cursor, n_cursor;
    t_choice         r_choice, n_choice;
    logic [8:0]      r_burst, n_burst;

    // captured transaction and per-cell compare results
    t_in                    r_in;
    logic [QUEUE_DEPTH-1:0] r_lt;

    // result register
    logic r_out_valid;
    t_out r_out, n_out;

    t_entry                   w_new;
    t_entry [QUEUE_DEPTH-1:0] w_rd_data;
    t_entry [QUEUE_DEPTH-1:0] w_wr_data;
    t_chain_ctl               w_rd_ctl, w_wr_ctl;
    logic [IDXW-1:0]          w_rd_idx, w_wr_idx;
    logic                     w_finish;
    logic                     w_accept;

    assign w_new    = {r_in.req_tag, r_in.cylinder, r_in.block_number};
    assign w_accept = i_in_valid && !o_in_stall;
    assign w_finish = (r_state == S_EXEC) && (!r_out_valid || !i_out_stall);

    // key compare in every write cell, registered for the execute cycle
    logic [QUEUE_DEPTH-1:0] w_lt;
    always_comb begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            if (r_sort_cyl) begin
                w_lt[i] = (CNTW'(i) < r_wr_count) &&
                          (w_wr_data[i][47:0] < w_new[47:0]);
            end else begin
                w_lt[i] = (CNTW'(i) < r_wr_count) &&
                          (w_wr_data[i][31:0] < w_new[31:0]);
            end
        end
    end

    // insert position: first cell at or after the scan start whose key is
    // not below the new key, found by a ripple along the row
    logic [IDXW-1:0] w_start;
    logic [IDXW-1:0] w_pos;
    always_comb begin
        logic seen;
        logic here;
        seen    = 1'b0;
        w_pos   = '0;
        w_start = ((CNTW'(r_cursor) < r_wr_count) && r_lt[r_cursor]) ? r_cursor : '0;
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            here = (IDXW'(i) >= w_start) && !r_lt[i];
            if (here && !seen) begin
                w_pos = IDXW'(i);
            end
            seen = seen | here;
        end
    end

    // execute: put, or choose and optionally remove
    always_comb begin
        logic [8:0] old_burst;
        logic       found;
        logic       is_rd;
        t_entry     chosen;
        logic [CNTW-1:0] dec_count;

        n_rd_count = r_rd_count;
        n_wr_count = r_wr_count;
        n_cursor   = r_cursor;
        n_choice   = r_choice;
        n_burst    = r_burst;
        n_out      = '0;
        w_rd_ctl   = '{op: CHAIN_HOLD, use_new: 1'b0};
        w_wr_ctl   = '{op: CHAIN_HOLD, use_new: 1'b0};
        w_rd_idx   = '0;
        w_wr_idx   = '0;
        old_burst  = r_burst;
        found      = 1'b0;
        is_rd      = 1'b0;
        chosen     = '0;
        dec_count  = r_wr_count - CNTW'(1);

        unique case (t_cmd'(r_in.command))
            CMD_PUT: begin
                if (r_in.is_read) begin
                    if (r_rd_count < CNTW'(QUEUE_DEPTH)) begin
                        w_rd_ctl   = '{op: CHAIN_INSERT, use_new: 1'b1};
                        w_rd_idx   = r_rd_count[IDXW-1:0];
                        n_rd_count = r_rd_count + CNTW'(1);
                        n_out.accepted = 1'b1;
                    end
                end else if (r_wr_count < CNTW'(QUEUE_DEPTH)) begin
                    w_wr_ctl       = '{op: CHAIN_INSERT, use_new: 1'b1};
                    n_wr_count     = r_wr_count + CNTW'(1);
                    n_out.accepted = 1'b1;
                    if (r_wr_count == '0) begin
                        w_wr_idx = '0;
                        n_cursor = '0;
                    end else begin
                        w_wr_idx = w_pos;
                        if (w_pos <= r_cursor) begin
                            n_cursor = r_cursor + IDXW'(1);
                        end
                    end
                end
            end
            CMD_PEEK, CMD_GET: begin
                // choice is made only when none is held
                if (r_choice == CHOICE_NONE) begin
                    if (r_rd_count == '0) begin
                        n_choice = (r_wr_count != '0) ? CHOICE_WRITE : CHOICE_NONE;
                        n_burst  = '0;
                    end else if (r_wr_count == '0) begin
                        n_choice = CHOICE_READ;
                        n_burst  = '0;
                    end else begin
                        n_burst = r_burst + 9'd1;
                        if (old_burst < {1'b0, r_rd_limit}) begin
                            n_choice = CHOICE_READ;
                        end else if (n_burst < ({1'b0, r_rd_limit} + {1'b0, r_wr_limit})) begin
                            n_choice = CHOICE_WRITE;
                        end else begin
                            n_choice = CHOICE_READ;
                            n_burst  = '0;
                        end
                    end
                end

                if (n_choice == CHOICE_READ && r_rd_count != '0) begin
                    chosen = w_rd_data[0];
                    found  = 1'b1;
                    is_rd  = 1'b1;
                end else if (n_choice == CHOICE_WRITE && CNTW'(r_cursor) < r_wr_count) begin
                    chosen = w_wr_data[r_cursor];
                    found  = 1'b1;
                end else begin
                    n_choice = CHOICE_NONE;
                end

                if (found) begin
                    n_out.found        = 1'b1;
                    n_out.out_tag      = chosen[63:48];
                    n_out.out_is_read  = is_rd;
                    n_out.out_cylinder = chosen[47:32];
                    n_out.out_block    = chosen[31:0];
                    if (t_cmd'(r_in.command) == CMD_GET) begin
                        n_choice = CHOICE_NONE;
                        if (is_rd) begin
                            w_rd_ctl   = '{op: CHAIN_REMOVE, use_new: 1'b1};
                            w_rd_idx   = '0;
                            n_rd_count = r_rd_count - CNTW'(1);
                        end else begin
                            w_wr_ctl   = '{op: CHAIN_REMOVE, use_new: 1'b1};
                            w_wr_idx   = r_cursor;
                            n_wr_count = dec_count;
                            // removing the last write wraps the scan
                            if (CNTW'(r_cursor) >= dec_count) begin
                                n_cursor = '0;
                            end
                        end
                    end
                end
            end
            CMD_NOP: begin
                n_out = '0;
            end
            default: n_out = '0;
        endcase

        // chain changes only in the cycle the transaction finishes
        if (!w_finish) begin
            w_rd_ctl.use_new = 1'b0;
            w_wr_ctl.use_new = 1'b0;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (w_accept) n_state = S_CMP;
            S_CMP:   n_state = S_EXEC;
            S_EXEC:  if (w_finish) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sort_cyl  <= 1'b1;
            r_rd_limit  <= 8'(RdBurstReset);
            r_wr_limit  <= 8'(WrBurstReset);
            r_rd_count  <= '0;
            r_wr_count  <= '0;
            r_cursor    <= '0;
            r_choice    <= CHOICE_NONE;
            r_burst     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_idx))
                    CFG_SORT_BY_CYL: r_sort_cyl <= i_cfg_data[0];
                    CFG_RD_BURST:    r_rd_limit <= i_cfg_data;
                    CFG_WR_BURST:    r_wr_limit <= i_cfg_data;
                    CFG_UNUSED:      r_sort_cyl <= r_sort_cyl;
                    default:         r_sort_cyl <= r_sort_cyl;
                endcase
            end
            if (w_finish) begin
                r_rd_count  <= n_rd_count;
                r_wr_count  <= n_wr_count;
                r_cursor    <= n_cursor;
                r_choice    <= n_choice;
                r_burst     <= n_burst;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in <= i_in_data;
        end
        if (r_state == S_CMP) begin
            r_lt <= w_lt;
        end
        if (w_finish) begin
            r_out <= n_out;
        end
    end

    rpwe_chain #(.DEPTH(QUEUE_DEPTH)) u_rd_chain (
        .i_clk  (i_clk),
        .i_ctl  (w_rd_ctl),
        .i_idx  (w_rd_idx),
        .i_new  (w_new),
        .o_data (w_rd_data)
    );

    rpwe_chain #(.DEPTH(QUEUE_DEPTH)) u_wr_chain (
        .i_clk  (i_clk),
        .i_ctl  (w_wr_ctl),
        .i_idx  (w_wr_idx),
        .i_new  (w_new),
        .o_data (w_wr_data)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTH
    a_counts_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rd_count <= CNTW'(QUEUE_DEPTH)) && (r_wr_count <= CNTW'(QUEUE_DEPTH)))
        else $error("queue count beyond depth");
    a_cursor_in_list: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wr_count == '0) || (CNTW'(r_cursor) < r_wr_count))
        else $error("write cursor outside the list");
    a_empty_cursor_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wr_count == '0) |-> (r_cursor == '0))
        else $error("cursor not at head of empty list");
    a_state_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("state register not one-hot");
    a_result_follows_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_finish |=> r_out_valid)
        else $error("finished transaction left no result");
`endif

endmodule

@@ hdl/rpwe_cell.sv @@
// rpwe_cell: one storage cell of a request chain
// depends on rpwe_pkg
module rpwe_cell (
    input  logic              i_clk,
    input  rpwe_pkg::t_cell_op i_op,
    input  rpwe_pkg::t_entry  i_new,
    input  rpwe_pkg::t_entry  i_prev,
    input  rpwe_pkg::t_entry  i_next,
    output rpwe_pkg::t_entry  o_data
);
    import rpwe_pkg::*;

    t_entry r_data;
    t_entry n_data;

    always_comb begin
        unique case (i_op)
            CELL_HOLD: n_data = r_data;
            CELL_NEW:  n_data = i_new;
            CELL_PREV: n_data = i_prev;
            CELL_NEXT: n_data = i_next;
            default:   n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

@@ hdl/rpwe_chain.sv @@
// rpwe_chain: row of cells that inserts or removes at one position per cycle
// depends on rpwe_pkg and rpwe_cell
module rpwe_chain #(
    parameter int DEPTH = rpwe_pkg::QueueDepth
) (
    input  logic                            i_clk,
    input  rpwe_pkg::t_chain_ctl            i_ctl,
    input  logic [$clog2(DEPTH)-1:0]        i_idx,
    input  rpwe_pkg::t_entry                i_new,
    output rpwe_pkg::t_entry [DEPTH-1:0]    o_data
);
    import rpwe_pkg::*;

    localparam int IDXW = $clog2(DEPTH);

    t_entry [DEPTH-1:0] w_data;

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            t_cell_op w_op;
            t_entry   w_prev;
            t_entry   w_next;

            assign w_prev = (g == 0) ? i_new : w_data[(g == 0) ? 0 : g-1];
            assign w_next = (g == DEPTH-1) ? w_data[g] : w_data[(g == DEPTH-1) ? g : g+1];

            always_comb begin
                w_op = CELL_HOLD;
                if (i_ctl.use_new) begin
                    unique case (i_ctl.op)
                        CHAIN_INSERT: begin
                            if (IDXW'(g) == i_idx) begin
                                w_op = CELL_NEW;
                            end else if (IDXW'(g) > i_idx) begin
                                w_op = CELL_PREV;
                            end
                        end
                        CHAIN_REMOVE: begin
                            if (IDXW'(g) >= i_idx && g != DEPTH-1) begin
                                w_op = CELL_NEXT;
                            end
                        end
                        default: w_op = CELL_HOLD;
                    endcase
                end
            end

            rpwe_cell u_cell (
                .i_clk  (i_clk),
                .i_op   (w_op),
                .i_new  (i_new),
                .i_prev (w_prev),
                .i_next (w_next),
                .o_data (w_data[g])
            );
        end
    endgenerate

    assign o_data = w_data;

endmodule

@@ test/read_priority_write_elevator_tb.sv @@
// read_priority_write_elevator_tb: self-checking bench for the disk request scheduler
// depends on rpwe_pkg and read_priority_write_elevator
`timescale 1ns / 100ps

module read_priority_write_elevator_tb;
    import rpwe_pkg::*;

    localparam int Depth      = QueueDepth;
    localparam int CycleLimit = 400000;

    logic   i_clk;
    logic   i_rst_n;
    logic   in_valid;
    logic   in_stall;
    t_in    in_data;
    logic   out_valid;
    logic   out_stall;
    t_out   out_data;
    logic   cfg_we;
    logic [1:0] cfg_idx;
    logic [7:0] cfg_data;

    read_priority_write_elevator dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    // scheduler state mirrored in the bench
    logic [63:0] rd_fifo[$];
    logic [63:0] wr_list[$];
    int          cursor;
    t_choice     choice;
    logic [8:0]  burst;
    logic        by_cyl;
    logic [7:0]  rd_limit;
    logic [7:0]  wr_limit;

    t_in    pending_reqs[$];
    t_out   expected_results[$];
    int     errors;
    int     cycles;

    // long receiver hold-off and sender pause requests
    logic   hold_req;
    int     hold_left;
    logic   drain_pause;
    int     burst_left;
    int     gap_left;
    int     stall_mode;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [47:0] sort_key(logic [63:0] e);
        return by_cyl ? e[47:0] : {16'd0, e[31:0]};
    endfunction

    function automatic void insert_write(logic [63:0] e);
        int pos;
        pos = 0;
        if (wr_list.size() == 0) begin
            wr_list.push_back(e);
            cursor = 0;
            return;
        end
        if (cursor < wr_list.size() && sort_key(wr_list[cursor]) < sort_key(e))
            pos = cursor;
        while (pos < wr_list.size() && sort_key(wr_list[pos]) < sort_key(e))
            pos++;
        wr_list.insert(pos, e);
        if (pos <= cursor)
            cursor++;
    endfunction

    function automatic void pick_next();
        logic [8:0] old;
        if (rd_fifo.size() == 0) begin
            choice = (wr_list.size() != 0) ? CHOICE_WRITE : CHOICE_NONE;
            burst  = '0;
        end else if (wr_list.size() == 0) begin
            choice = CHOICE_READ;
            burst  = '0;
        end else begin
            old   = burst;
            burst = burst + 9'd1;
            if (old < {1'b0, rd_limit})
                choice = CHOICE_READ;
            else if (burst < ({1'b0, rd_limit} + {1'b0, wr_limit}))
                choice = CHOICE_WRITE;
            else begin
                choice = CHOICE_READ;
                burst  = '0;
            end
        end
    endfunction

    // computes the scheduler's answer to one accepted request
    function automatic t_out schedule(t_in req);
        t_out        r;
        logic [63:0] e;
        logic [63:0] sel;
        logic        hit;
        logic        rd;
        r   = '0;
        hit = 1'b0;
        rd  = 1'b0;
        sel = '0;
        case (t_cmd'(req.command))
            CMD_PUT: begin
                e = {req.req_tag, req.cylinder, req.block_number};
                if (req.is_read) begin
                    if (rd_fifo.size() >= Depth) return r;
                    rd_fifo.push_back(e);
                end else begin
                    if (wr_list.size() >= Depth) return r;
                    insert_write(e);
                end
                r.accepted = 1'b1;
                return r;
            end
            CMD_NOP: return r;
            default: begin
            end
        endcase
        if (choice == CHOICE_NONE)
            pick_next();
        if (choice == CHOICE_READ && rd_fifo.size() != 0) begin
            sel = rd_fifo[0];
            hit = 1'b1;
            rd  = 1'b1;
        end else if (choice == CHOICE_WRITE && cursor < wr_list.size()) begin
            sel = wr_list[cursor];
            hit = 1'b1;
        end else begin
            choice = CHOICE_NONE;
        end
        if (hit) begin
            r.found        = 1'b1;
            r.out_tag      = sel[63:48];
            r.out_is_read  = rd;
            r.out_cylinder = sel[47:32];
            r.out_block    = sel[31:0];
            if (t_cmd'(req.command) == CMD_GET) begin
                if (rd)
                    void'(rd_fifo.pop_front());
                else begin
                    wr_list.delete(cursor);
                    if (cursor >= wr_list.size())
                        cursor = 0;
                end
                choice = CHOICE_NONE;
            end
        end
        return r;
    endfunction

    // driver: bursts of transactions with random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid   <= 1'b0;
            burst_left <= 0;
            gap_left   <= 0;
        end else if (in_valid && in_stall) begin
            // payload held until taken
        end else begin
            if (in_valid) begin
                expected_results.push_back(schedule(in_data));
                void'(pending_reqs.pop_front());
            end
            if (drain_pause || pending_reqs.size() == 0) begin
                in_valid <= 1'b0;
            end else if (gap_left > 0) begin
                in_valid <= 1'b0;
                gap_left <= gap_left - 1;
            end else begin
                in_valid <= 1'b1;
                in_data  <= pending_reqs[0];
                if (burst_left == 0) begin
                    burst_left <= $urandom_range(1, 30);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end
        end
    end

    // receiver stall pattern and long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_stall  <= 1'b0;
            hold_left  <= 0;
            stall_mode <= 0;
        end else begin
            if (hold_req && hold_left == 0)
                hold_left <= 300;
            else if (hold_left > 0)
                hold_left <= hold_left - 1;
            if ($urandom_range(0, 199) == 0)
                stall_mode <= $urandom_range(0, 2);
            case (stall_mode)
                0: out_stall <= (hold_left > 1);
                1: out_stall <= (hold_left > 1) || ($urandom_range(0, 3) == 0);
                default: out_stall <= (hold_left > 1) || ($urandom_range(0, 1) == 0);
            endcase
        end
    end

    // monitor: compare each result transaction with the oldest expectation
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && out_valid && !out_stall) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result transaction %h", out_data);
                errors++;
            end else begin
                want = expected_results.pop_front();
                if (out_data.accepted !== want.accepted) begin
                    $error("accepted: expected %h actual %h", want.accepted, out_data.accepted);
                    errors++;
                end
                if (out_data.found !== want.found) begin
                    $error("found: expected %h actual %h", want.found, out_data.found);
                    errors++;
                end
                if (out_data.out_tag !== want.out_tag) begin
                    $error("out_tag: expected %h actual %h", want.out_tag, out_data.out_tag);
                    errors++;
                end
                if (out_data.out_is_read !== want.out_is_read) begin
                    $error("out_is_read: expected %h actual %h", want.out_is_read,
                        out_data.out_is_read);
                    errors++;
                end
                if (out_data.out_cylinder !== want.out_cylinder) begin
                    $error("out_cylinder: expected %h actual %h", want.out_cylinder,
                        out_data.out_cylinder);
                    errors++;
                end
                if (out_data.out_block !== want.out_block) begin
                    $error("out_block: expected %h actual %h", want.out_block,
                        out_data.out_block);
                    errors++;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic add_req(t_cmd c, logic rd, logic [15:0] cyl, logic [31:0] blk);
        t_in t;
        t.command      = c;
        t.req_tag      = 16'($urandom());
        t.is_read      = rd;
        t.cylinder     = cyl;
        t.block_number = blk;
        pending_reqs.push_back(t);
    endtask

    // random put with keys drawn from a narrow range so equal keys happen
    task automatic add_put(logic rd);
        logic [15:0] cyl;
        logic [31:0] blk;
        cyl = ($urandom_range(0, 7) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 3));
        blk = ($urandom_range(0, 7) == 0) ? $urandom() : 32'($urandom_range(0, 15));
        add_req(CMD_PUT, rd, cyl, blk);
    endtask

    // wait until all queued requests are taken and every result has come back
    task automatic drain();
        while (pending_reqs.size() != 0 || in_valid || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_cfg(t_cfg_idx idx, logic [7:0] val);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        cfg_we   <= 1'b0;
        case (idx)
            CFG_SORT_BY_CYL: by_cyl   = val[0];
            CFG_RD_BURST:    rd_limit = val;
            CFG_WR_BURST:    wr_limit = val;
            default: begin
            end
        endcase
    endtask

    // one phase of random traffic; puts and gets are drawn equally often
    task automatic random_phase(int n);
        int k;
        for (k = 0; k < n; k++) begin
            case ($urandom_range(0, 19))
                0: add_req(CMD_NOP, 1'($urandom_range(0, 1)), 16'($urandom()), $urandom());
                1, 2, 3, 4, 5, 6, 7, 8: add_put(1'($urandom_range(0, 1)));
                9, 10, 11: add_req(CMD_PEEK, 1'($urandom_range(0, 1)), 16'($urandom()),
                    $urandom());
                default: add_req(CMD_GET, 1'($urandom_range(0, 1)), 16'($urandom()),
                    $urandom());
            endcase
        end
    endtask

    initial begin
        int k;
        i_rst_n     = 1'b0;
        in_valid    = 1'b0;
        in_data     = '0;
        out_stall   = 1'b0;
        cfg_we      = 1'b0;
        cfg_idx     = CFG_SORT_BY_CYL;
        cfg_data    = '0;
        hold_req    = 1'b0;
        drain_pause = 1'b0;
        errors      = 0;
        cycles      = 0;
        cursor      = 0;
        choice      = CHOICE_NONE;
        burst       = '0;
        by_cyl      = 1'b1;
        rd_limit    = 8'(RdBurstReset);
        wr_limit    = 8'(WrBurstReset);
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty lookups, field extremes, equal keys, cursor wrap, unused command
        add_req(CMD_PEEK, 1'b0, '0, '0);
        add_req(CMD_GET, 1'b1, '1, '1);
        add_req(CMD_PUT, 1'b0, 16'hffff, 32'hffffffff);
        add_req(CMD_PUT, 1'b0, 16'h0000, 32'h00000000);
        add_req(CMD_PUT, 1'b0, 16'h0000, 32'h00000000);
        add_req(CMD_PUT, 1'b1, 16'hffff, 32'h00000000);
        add_req(CMD_PUT, 1'b1, 16'h0000, 32'hffffffff);
        add_req(CMD_NOP, 1'b1, '1, '1);
        add_req(CMD_PEEK, 1'b0, '0, '0);
        for (k = 0; k < 6; k++)
            add_req(CMD_GET, 1'b0, '0, '0);
        add_req(CMD_PUT, 1'b0, 16'h0005, 32'h10);
        add_req(CMD_GET, 1'b0, '0, '0);
        add_req(CMD_PUT, 1'b0, 16'h0001, 32'h20);
        add_req(CMD_PUT, 1'b0, 16'h0009, 32'h01);
        add_req(CMD_GET, 1'b0, '0, '0);
        add_req(CMD_GET, 1'b0, '0, '0);
        add_req(CMD_GET, 1'b0, '0, '0);
        drain();

        // fill both stores past full while the receiver holds off
        hold_req = 1'b1;
        for (k = 0; k < 70; k++)
            add_put(1'(k % 2));
        wait (hold_left > 0);
        hold_req = 1'b0;
        drain();

        // sweep settings, extremes included, with random traffic in each
        for (k = 0; k < 6; k++) begin
            case (k)
                0: begin
                    write_cfg(CFG_SORT_BY_CYL, 8'd0);
                    write_cfg(CFG_RD_BURST, 8'd1);
                    write_cfg(CFG_WR_BURST, 8'd1);
                end
                1: begin
                    write_cfg(CFG_RD_BURST, 8'd255);
                    write_cfg(CFG_WR_BURST, 8'd255);
                end
                2: begin
                    write_cfg(CFG_SORT_BY_CYL, 8'd1);
                    write_cfg(CFG_RD_BURST, 8'd0);
                    write_cfg(CFG_WR_BURST, 8'd0);
                end
                3: begin
                    write_cfg(CFG_RD_BURST, 8'd2);
                    write_cfg(CFG_WR_BURST, 8'd3);
                end
                default: begin
                    write_cfg(CFG_SORT_BY_CYL, 8'($urandom_range(0, 1)));
                    write_cfg(CFG_RD_BURST, 8'($urandom_range(1, 6)));
                    write_cfg(CFG_WR_BURST, 8'($urandom_range(1, 6)));
                end
            endcase
            random_phase(160);
            // mid-phase, sender waits for every result before going on
            if (k == 3) begin
                repeat (200) @(posedge i_clk);
                drain_pause = 1'b1;
                while (in_valid || expected_results.size() != 0)
                    @(posedge i_clk);
                repeat (8) @(posedge i_clk);
                drain_pause = 1'b0;
            end
            drain();
        end

        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

@@ read_priority_write_elevator.f @@
hdl/rpwe_pkg.sv
hdl/rpwe_cell.sv
hdl/rpwe_chain.sv
hdl/read_priority_write_elevator.sv
test/read_priority_write_elevator_tb.sv
